// ===== design/lwws_pkg.sv =====
package lwws_pkg;

    // Item codes
    localparam logic ACT_WINDOW = 1'b0;
    localparam logic ACT_PIXEL  = 1'b1;

    // Controller command bytes
    localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
    localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
    localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

    // Byte position within one item
    typedef logic [3:0] t_pos;

    localparam t_pos POS_COL_CMD  = 4'd0;
    localparam t_pos POS_COL_X_HI = 4'd1;
    localparam t_pos POS_COL_X_LO = 4'd2;
    localparam t_pos POS_COL_E_HI = 4'd3;
    localparam t_pos POS_COL_E_LO = 4'd4;
    localparam t_pos POS_ROW_CMD  = 4'd5;
    localparam t_pos POS_ROW_Y_HI = 4'd6;
    localparam t_pos POS_ROW_Y_LO = 4'd7;
    localparam t_pos POS_ROW_E_HI = 4'd8;
    localparam t_pos POS_ROW_E_LO = 4'd9;
    localparam t_pos POS_MEM_CMD  = 4'd10;
    localparam t_pos POS_PIX_HI   = 4'd0;
    localparam t_pos POS_PIX_LO   = 4'd1;

    // Input beat
    typedef struct packed {
        logic        action;
        logic [8:0]  win_x;
        logic [8:0]  win_y;
        logic [8:0]  win_width;
        logic [8:0]  win_height;
        logic [15:0] pixel;
    } t_in_beat;

    // Output beat
    typedef struct packed {
        logic [7:0] spi_byte;
        logic       data_phase;
        logic       frame_end;
        logic       error;
        logic       last;
    } t_out_beat;

endpackage

// ===== design/lcd_window_write_stream.sv =====
// Window-write byte stream for an SPI display controller (RGB565).
// Input channel (i_in_valid / o_in_stall, i_in_beat): open-window items and
// pixel items. Output channel (o_out_valid / i_out_stall, o_out_beat): one
// byte per beat with data/command flag, frame-end flag, error and last.
// Config channel (i_cfg_valid / o_cfg_ready, i_cfg_data): panel_ready bit,
// always ready; write it only while the block is idle.
// An accepted item sits in the item register and the byte formatter emits
// one byte per cycle into the output register while the output is not
// stalled: 11 beats for an admitted window, 2 for a pixel, 1 error beat
// for a rejected item, the first of them after the item has entered the
// item register. The next item is accepted in the cycle its predecessor's
// last byte is loaded, so it is taken while that byte waits in the output.
// The window checks and the window-size product are done when the first
// byte of an item is loaded.
// Synchronous active-low reset clears panel_ready, the open-window state and
// all valid flags. A stall on the output holds the output register; the
// item register then holds too and the input is stalled if it holds an item.
module lcd_window_write_stream #(
    parameter int PANEL_WIDTH  = 320,
    parameter int PANEL_HEIGHT = 240
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lwws_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lwws_pkg::t_out_beat o_out_beat,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    localparam int PIX_W = $clog2(PANEL_WIDTH * PANEL_HEIGHT + 1);
    localparam logic [9:0] PW = 10'(PANEL_WIDTH);
    localparam logic [9:0] PH = 10'(PANEL_HEIGHT);

    logic                r_panel_ready;
    logic                r_window_open, n_window_open;
    logic [PIX_W-1:0]    r_pixels_left, n_pixels_left;
    logic                r_item_valid;
    lwws_pkg::t_in_beat  r_item;
    lwws_pkg::t_pos      r_pos;
    logic                r_ok;
    logic                r_out_valid;
    lwws_pkg::t_out_beat r_out;

    logic                w_advance;
    logic                w_fire;
    logic                w_first;
    logic                w_check_ok;
    logic                w_item_ok;
    logic                w_item_done;
    logic                w_accept;
    logic [17:0]         w_area;
    lwws_pkg::t_out_beat w_beat;

    // Handshakes
    assign w_advance   = !r_out_valid || !i_out_stall;
    assign w_fire      = r_item_valid && w_advance;
    assign w_item_done = w_fire && w_beat.last;
    assign o_in_stall  = r_item_valid && !w_item_done;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;
    assign o_cfg_ready = 1'b1;

    // Item checks, evaluated on the first byte
    assign w_first = (r_pos == '0);
    always_comb begin
        if (r_item.action == lwws_pkg::ACT_WINDOW) begin
            w_check_ok = r_panel_ready && !r_window_open
                && (r_item.win_width != '0) && (r_item.win_height != '0)
                && ({1'b0, r_item.win_x} < PW) && ({1'b0, r_item.win_y} < PH)
                && ({1'b0, r_item.win_x} + {1'b0, r_item.win_width} <= PW)
                && ({1'b0, r_item.win_y} + {1'b0, r_item.win_height} <= PH);
        end else begin
            w_check_ok = r_window_open && (r_pixels_left != '0);
        end
    end
    assign w_item_ok = w_first ? w_check_ok : r_ok;
    assign w_area    = 18'(r_item.win_width) * 18'(r_item.win_height);

    lwws_byte_fmt u_fmt (
        .i_beat    (r_item),
        .i_pos     (r_pos),
        .i_ok      (w_item_ok),
        .i_pix_end (r_pixels_left == '0),
        .o_beat    (w_beat)
    );

    // Window state update on the first byte of an admitted item
    always_comb begin
        n_window_open = r_window_open;
        n_pixels_left = r_pixels_left;
        if (w_fire && w_first && w_check_ok) begin
            if (r_item.action == lwws_pkg::ACT_WINDOW) begin
                n_window_open = 1'b1;
                n_pixels_left = PIX_W'(w_area);
            end else begin
                n_pixels_left = r_pixels_left - PIX_W'(1);
                if (r_pixels_left == PIX_W'(1)) begin
                    n_window_open = 1'b0;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel_ready <= 1'b0;
            r_window_open <= 1'b0;
            r_pixels_left <= '0;
            r_item_valid  <= 1'b0;
            r_pos         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_panel_ready <= i_cfg_data;
            end
            r_window_open <= n_window_open;
            r_pixels_left <= n_pixels_left;
            if (w_accept) begin
                r_item_valid <= 1'b1;
            end else if (w_item_done) begin
                r_item_valid <= 1'b0;
            end
            if (w_fire) begin
                r_pos <= w_beat.last ? '0 : r_pos + 4'd1;
            end
            if (w_advance) begin
                r_out_valid <= r_item_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in_beat;
        end
        if (w_fire) begin
            r_ok  <= w_item_ok;
            r_out <= w_beat;
        end
    end

endmodule

// ===== design/lwws_byte_fmt.sv =====
module lwws_byte_fmt (
    input  lwws_pkg::t_in_beat  i_beat,
    input  lwws_pkg::t_pos      i_pos,
    input  logic                i_ok,
    input  logic                i_pix_end,
    output lwws_pkg::t_out_beat o_beat
);

    logic [9:0] w_last_col;
    logic [9:0] w_last_row;

    // Window end coordinates (inclusive)
    assign w_last_col = {1'b0, i_beat.win_x} + {1'b0, i_beat.win_width} - 10'd1;
    assign w_last_row = {1'b0, i_beat.win_y} + {1'b0, i_beat.win_height} - 10'd1;

    // Select the byte for the current position
    always_comb begin
        o_beat = '0;
        if (!i_ok) begin
            o_beat.error = 1'b1;
            o_beat.last  = 1'b1;
        end else if (i_beat.action == lwws_pkg::ACT_PIXEL) begin
            o_beat.data_phase = 1'b1;
            unique case (i_pos)
                lwws_pkg::POS_PIX_HI: begin
                    o_beat.spi_byte = i_beat.pixel[15:8];
                end
                lwws_pkg::POS_PIX_LO: begin
                    o_beat.spi_byte  = i_beat.pixel[7:0];
                    o_beat.frame_end = i_pix_end;
                    o_beat.last      = 1'b1;
                end
                default: begin
                    o_beat.last = 1'b1;
                end
            endcase
        end else begin
            o_beat.data_phase = 1'b1;
            unique case (i_pos)
                lwws_pkg::POS_COL_CMD: begin
                    o_beat.spi_byte   = lwws_pkg::CMD_COLUMN_SET;
                    o_beat.data_phase = 1'b0;
                end
                lwws_pkg::POS_COL_X_HI: o_beat.spi_byte = {7'd0, i_beat.win_x[8]};
                lwws_pkg::POS_COL_X_LO: o_beat.spi_byte = i_beat.win_x[7:0];
                lwws_pkg::POS_COL_E_HI: o_beat.spi_byte = {6'd0, w_last_col[9:8]};
                lwws_pkg::POS_COL_E_LO: begin
                    o_beat.spi_byte  = w_last_col[7:0];
                    o_beat.frame_end = 1'b1;
                end
                lwws_pkg::POS_ROW_CMD: begin
                    o_beat.spi_byte   = lwws_pkg::CMD_ROW_SET;
                    o_beat.data_phase = 1'b0;
                end
                lwws_pkg::POS_ROW_Y_HI: o_beat.spi_byte = {7'd0, i_beat.win_y[8]};
                lwws_pkg::POS_ROW_Y_LO: o_beat.spi_byte = i_beat.win_y[7:0];
                lwws_pkg::POS_ROW_E_HI: o_beat.spi_byte = {6'd0, w_last_row[9:8]};
                lwws_pkg::POS_ROW_E_LO: begin
                    o_beat.spi_byte  = w_last_row[7:0];
                    o_beat.frame_end = 1'b1;
                end
                lwws_pkg::POS_MEM_CMD: begin
                    o_beat.spi_byte   = lwws_pkg::CMD_MEMORY_WRITE;
                    o_beat.data_phase = 1'b0;
                    o_beat.last       = 1'b1;
                end
                default: begin
                    o_beat.last = 1'b1;
                end
            endcase
        end
    end

endmodule

// ===== design/lwws_check.sv =====
module lwws_check (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input lwws_pkg::t_out_beat o_out_beat
);

    // Output beat held under stall
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("output beat changed while stalled");

    // Error beat is a lone, empty beat
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.error |-> o_out_beat.last
            && (o_out_beat.spi_byte == 8'h00) && !o_out_beat.data_phase
            && !o_out_beat.frame_end)
        else $error("malformed error beat");

    // Command bytes are only the three controller commands
    a_cmd_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_beat.error && !o_out_beat.data_phase |->
            (o_out_beat.spi_byte == lwws_pkg::CMD_COLUMN_SET)
            || (o_out_beat.spi_byte == lwws_pkg::CMD_ROW_SET)
            || (o_out_beat.spi_byte == lwws_pkg::CMD_MEMORY_WRITE))
        else $error("unexpected command byte");

    // Chip select is only released after a data byte
    a_fe_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.frame_end |->
            o_out_beat.data_phase && !o_out_beat.error)
        else $error("frame end on command or error beat");

endmodule

bind lcd_window_write_stream lwws_check u_lwws_check (.*);

// ===== sim/lcd_window_write_stream_tb.sv =====
`timescale 1ns / 100ps

module lcd_window_write_stream_tb;

    localparam int PANEL_W        = 320;
    localparam int PANEL_H        = 240;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;
    localparam int LONG_HOLD      = 60;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    lwws_pkg::t_in_beat  i_in_beat   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    lwws_pkg::t_out_beat o_out_beat;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_data  = 1'b0;

    // Byte stream the panel should see, oldest first
    lwws_pkg::t_out_beat exp_bytes[$];

    // Predicted block state
    bit pred_ready;
    bit pred_open;
    int pred_left;

    int fail_count;
    int quiet_cycles;

    // Idling controls
    bit tx_gaps_on = 1'b1;
    bit rx_gaps_on = 1'b1;
    int hold_req;
    int stall_left;
    int open_left;

    lcd_window_write_stream #(
        .PANEL_WIDTH  (PANEL_W),
        .PANEL_HEIGHT (PANEL_H)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic void push_byte(logic [7:0] value, logic dc, logic fe, logic err,
                                      logic lst);
        lwws_pkg::t_out_beat o;
        o.spi_byte   = value;
        o.data_phase = dc;
        o.frame_end  = fe;
        o.error      = err;
        o.last       = lst;
        exp_bytes.push_back(o);
    endfunction

    // Expected SPI bytes for one accepted beat; updates the predicted state
    function automatic void predict_spi_bytes(lwws_pkg::t_in_beat b);
        int x, y, w, h, lx, ly;
        x = int'(b.win_x);
        y = int'(b.win_y);
        w = int'(b.win_width);
        h = int'(b.win_height);
        if (b.action == lwws_pkg::ACT_WINDOW) begin
            if (!pred_ready || pred_open || w == 0 || h == 0 || x >= PANEL_W ||
                y >= PANEL_H || w > PANEL_W - x || h > PANEL_H - y) begin
                push_byte(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
            end else begin
                lx = x + w - 1;
                ly = y + h - 1;
                push_byte(lwws_pkg::CMD_COLUMN_SET, 1'b0, 1'b0, 1'b0, 1'b0);
                push_byte(8'(x >> 8), 1'b1, 1'b0, 1'b0, 1'b0);
                push_byte(8'(x), 1'b1, 1'b0, 1'b0, 1'b0);
                push_byte(8'(lx >> 8), 1'b1, 1'b0, 1'b0, 1'b0);
                push_byte(8'(lx), 1'b1, 1'b1, 1'b0, 1'b0);
                push_byte(lwws_pkg::CMD_ROW_SET, 1'b0, 1'b0, 1'b0, 1'b0);
                push_byte(8'(y >> 8), 1'b1, 1'b0, 1'b0, 1'b0);
                push_byte(8'(y), 1'b1, 1'b0, 1'b0, 1'b0);
                push_byte(8'(ly >> 8), 1'b1, 1'b0, 1'b0, 1'b0);
                push_byte(8'(ly), 1'b1, 1'b1, 1'b0, 1'b0);
                push_byte(lwws_pkg::CMD_MEMORY_WRITE, 1'b0, 1'b0, 1'b0, 1'b1);
                pred_open = 1'b1;
                pred_left = w * h;
            end
        end else if (!pred_open || pred_left == 0) begin
            push_byte(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
        end else begin
            pred_left--;
            push_byte(b.pixel[15:8], 1'b1, 1'b0, 1'b0, 1'b0);
            push_byte(b.pixel[7:0], 1'b1, pred_left == 0, 1'b0, 1'b1);
            if (pred_left == 0) pred_open = 1'b0;
        end
    endfunction

    function automatic lwws_pkg::t_in_beat win_beat(int x, int y, int w, int h);
        lwws_pkg::t_in_beat b;
        b.action     = lwws_pkg::ACT_WINDOW;
        b.win_x      = 9'(x);
        b.win_y      = 9'(y);
        b.win_width  = 9'(w);
        b.win_height = 9'(h);
        b.pixel      = 16'($urandom);
        return b;
    endfunction

    function automatic lwws_pkg::t_in_beat pix_beat(logic [15:0] p);
        lwws_pkg::t_in_beat b;
        b.action     = lwws_pkg::ACT_PIXEL;
        b.win_x      = 9'($urandom);
        b.win_y      = 9'($urandom);
        b.win_width  = 9'($urandom);
        b.win_height = 9'($urandom);
        b.pixel      = p;
        return b;
    endfunction

    // Offer one beat, hold it until taken, then predict its bytes
    task automatic send_beat(lwws_pkg::t_in_beat b);
        int gap;
        gap = (tx_gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        do @(posedge i_clk); while (o_in_stall || !i_rst_n);
        predict_spi_bytes(b);
    endtask

    // Stop offering and wait until every expected byte has come out
    task automatic drain_bytes();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (exp_bytes.size() != 0);
    endtask

    task automatic write_panel_ready(bit value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pred_ready = value;
    endtask

    // Everything is rejected until the panel is marked ready
    task automatic test_not_ready();
        send_beat(win_beat(0, 0, 1, 1));
        send_beat(pix_beat(16'h1234));
        drain_bytes();
        write_panel_ready(1'b1);
    endtask

    // Window checks: zero size, origin off panel, window running past the edge, then a pixel with no window open
    task automatic test_window_checks();
        send_beat(win_beat(0, 0, 0, 1));
        send_beat(win_beat(0, 0, 1, 0));
        send_beat(win_beat(PANEL_W, 0, 1, 1));
        send_beat(win_beat(0, PANEL_H, 1, 1));
        send_beat(win_beat(PANEL_W - 1, 0, 2, 1));
        send_beat(win_beat(0, PANEL_H - 1, 1, 2));
        send_beat(win_beat(511, 511, 511, 511));
        send_beat(pix_beat(16'hFFFF));
    endtask

    // Corner windows, pixel extremes and a column range crossing 256
    task automatic test_small_windows();
        send_beat(win_beat(PANEL_W - 1, PANEL_H - 1, 1, 1));
        send_beat(pix_beat(16'hFFFF));
        send_beat(win_beat(0, 0, 1, 1));
        send_beat(pix_beat(16'h0000));
        send_beat(win_beat(255, 0, 2, 2));
        repeat (4) send_beat(pix_beat(16'($urandom)));
    endtask

    // New window while pixels are outstanding, then a pixel after the frame
    task automatic test_open_while_busy();
        send_beat(win_beat(10, 20, 2, 1));
        send_beat(pix_beat(16'hA5A5));
        send_beat(win_beat(0, 0, 1, 1));
        send_beat(pix_beat(16'h5A5A));
        send_beat(pix_beat(16'h0F0F));
    endtask

    // Ready cleared mid-window: the open window still completes
    task automatic test_ready_drop();
        send_beat(win_beat(100, 100, 1, 2));
        send_beat(pix_beat(16'h8001));
        drain_bytes();
        write_panel_ready(1'b0);
        send_beat(pix_beat(16'h7FFE));
        send_beat(win_beat(0, 0, 1, 1));
        drain_bytes();
        write_panel_ready(1'b1);
    endtask

    // Full-width row write
    task automatic test_full_row();
        send_beat(win_beat(0, $urandom_range(0, PANEL_H - 1), PANEL_W, 1));
        repeat (PANEL_W) send_beat(pix_beat(16'($urandom)));
    endtask

    // Receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        hold_req   = LONG_HOLD;
        repeat (5) begin
            send_beat(win_beat($urandom_range(0, PANEL_W - 2), $urandom_range(0, PANEL_H - 2),
                               2, 2));
            repeat (4) send_beat(pix_beat(16'($urandom)));
        end
        drain_bytes();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    // Mostly complete windows with random content, plus noise
    task automatic run_random(int count);
        lwws_pkg::t_in_beat b;
        logic [63:0]        rnd;
        int                 kind, x, y, w, h;
        repeat (count) begin
            kind = $urandom_range(0, 9);
            if (pred_open && kind < 8) begin
                b = pix_beat(16'($urandom));
            end else if (!pred_open && kind < 6) begin
                w = $urandom_range(1, 6);
                h = $urandom_range(1, 4);
                if (kind == 0) w = $urandom_range(1, 24);
                x = ($urandom_range(0, 3) == 0) ? PANEL_W - w : $urandom_range(0, PANEL_W - w);
                y = ($urandom_range(0, 3) == 0) ? PANEL_H - h : $urandom_range(0, PANEL_H - h);
                b = win_beat(x, y, w, h);
            end else begin
                rnd = {$urandom, $urandom};
                b = rnd[$bits(lwws_pkg::t_in_beat)-1:0];
                x = int'(b.win_x);
                y = int'(b.win_y);
                w = int'(b.win_width);
                h = int'(b.win_height);
                // keep admitted noise windows small so sequences stay varied
                if (b.action == lwws_pkg::ACT_WINDOW && w > 0 && h > 0 && x < PANEL_W &&
                    y < PANEL_H && w <= PANEL_W - x && h <= PANEL_H - y && w * h > 48)
                    b.win_height = 9'd0;
            end
            send_beat(b);
        end
    endtask

    task automatic test_random();
        run_random(40);
        drain_bytes();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        run_random(20);
        drain_bytes();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        write_panel_ready(1'b0);
        run_random(10);
        drain_bytes();
        write_panel_ready(1'b1);
        run_random(26);
    endtask

    // Receiver stall pattern, including the long hold-off
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            stall_left = hold_req;
            hold_req   = 0;
        end
        if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!rx_gaps_on || open_left != 0) begin
            if (open_left != 0) open_left--;
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 2) == 0) begin
            stall_left = pick_gap() - 1;
            i_out_stall <= 1'b1;
        end else begin
            open_left = $urandom_range(0, 8);
            i_out_stall <= 1'b0;
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each output beat with the oldest expected byte
    always @(posedge i_clk) begin
        lwws_pkg::t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_bytes.size() == 0) begin
                $error("unexpected beat: spi_byte 0x%0h error %0b", o_out_beat.spi_byte,
                       o_out_beat.error);
                fail_count++;
            end else begin
                want = exp_bytes.pop_front();
                check_field("spi_byte", want.spi_byte, o_out_beat.spi_byte);
                check_field("data_phase", 8'(want.data_phase), 8'(o_out_beat.data_phase));
                check_field("frame_end", 8'(want.frame_end), 8'(o_out_beat.frame_end));
                check_field("error", 8'(want.error), 8'(o_out_beat.error));
                check_field("last", 8'(want.last), 8'(o_out_beat.last));
            end
        end
    end

    // Watchdog: ends the run when no channel moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        pred_ready = 1'b0;
        pred_open  = 1'b0;
        pred_left  = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_not_ready();
        test_window_checks();
        test_small_windows();
        test_open_while_busy();
        test_ready_drop();
        test_full_row();
        test_backpressure();
        test_random();

        drain_bytes();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (exp_bytes.size() != 0) begin
            $error("%0d expected bytes never arrived", exp_bytes.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
